// ===== rtl/core/psrb_pkg.sv =====
// shared types, field widths, status codes and parameter defaults for the
// per-peer sequence reorder buffer; no dependencies
`default_nettype none

package psrb_pkg;

  // parameter defaults
  localparam int DEF_PEERS       = 16;
  localparam int DEF_WINDOW      = 16;
  localparam int DEF_HANDLE_BITS = 16;

  // results one input may cause, and the counter that walks them
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = 4;

  // fixed field widths
  localparam int SEQ_W    = 32;
  localparam int HANDLE_W = 16;
  localparam int PEER_W   = 4;
  localparam int STATUS_W = 3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_PASS       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DELIVER    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HELD       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DROP       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NUMBERED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UNNUMBERED = 3'd5;

  // item kinds
  localparam logic KIND_RX = 1'b0;
  localparam logic KIND_TX = 1'b1;

  typedef struct packed {
    logic                local_req;
    logic                numbered;
    logic [HANDLE_W-1:0] handle;
    logic [SEQ_W-1:0]    seq;
    logic [PEER_W-1:0]   peer;
    logic                kind;
  } in_beat_t;

  typedef struct packed {
    logic                last;
    logic [SEQ_W-1:0]    seq;
    logic [HANDLE_W-1:0] handle;
    logic [STATUS_W-1:0] status;
  } res_t;

  // index bits for a store of n entries, at least one
  function automatic int idx_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // hold span, capped so a drain fits in one run of results
  function automatic int span_of(input int w);
    return (w < MAX_RESULTS) ? w : MAX_RESULTS;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/psrb_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// depends on psrb_pkg for index width
`default_nettype none

module psrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [psrb_pkg::idx_bits(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic                                 re,
  input  wire logic [psrb_pkg::idx_bits(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/psrb_seq.sv =====
// sequencer: reads a peer's counters and hold mask, decides, drains held
// handles and writes back; uses psrb_pkg, drives the two psrb_ram instances
`default_nettype none

module psrb_seq #(
  parameter int PEERS       = psrb_pkg::DEF_PEERS,
  parameter int WINDOW      = psrb_pkg::DEF_WINDOW,
  parameter int HANDLE_BITS = psrb_pkg::DEF_HANDLE_BITS,
  localparam int PW   = psrb_pkg::idx_bits(PEERS),
  localparam int SPAN = psrb_pkg::span_of(WINDOW),
  localparam int SB   = $clog2(SPAN),
  localparam int NS   = 1 << SB,
  localparam int HB   = (HANDLE_BITS < psrb_pkg::HANDLE_W) ? HANDLE_BITS
                                                           : psrb_pkg::HANDLE_W,
  localparam int PSW  = 2 * psrb_pkg::SEQ_W + NS,
  localparam int HAW  = PW + SB
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire psrb_pkg::in_beat_t in_beat,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output psrb_pkg::res_t          res,
  output logic                    ps_we,
  output logic [PW-1:0]           ps_waddr,
  output logic [PSW-1:0]          ps_wdata,
  output logic                    ps_re,
  output logic [PW-1:0]           ps_raddr,
  input  wire logic [PSW-1:0]     ps_rdata,
  output logic                    hd_we,
  output logic [HAW-1:0]          hd_waddr,
  output logic [HB-1:0]           hd_wdata,
  output logic                    hd_re,
  output logic [HAW-1:0]          hd_raddr,
  input  wire logic [HB-1:0]      hd_rdata
);

  localparam int SW = psrb_pkg::SEQ_W;
  localparam int CW = psrb_pkg::CNT_W;
  localparam logic [psrb_pkg::HANDLE_W-1:0] HMASK =
    psrb_pkg::HANDLE_W'((64'd1 << HB) - 64'd1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  // peer field folded onto the peer range
  logic [PW-1:0] peer_tbl [16];
  for (genvar gi = 0; gi < 16; gi++) begin : g_peer_mod
    localparam int PM = gi % PEERS;
    assign peer_tbl[gi] = PW'(PM);
  end

  logic [1:0]         state_r, state_nxt;
  logic [PW-1:0]      clr_ptr_r, clr_ptr_nxt;
  psrb_pkg::in_beat_t beat_r, beat_nxt;
  logic [PW-1:0]      p_r, p_nxt;
  logic [SW-1:0]      exp_r, exp_nxt;
  logic [NS-1:0]      mask_r, mask_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;

  logic               accept;
  logic [SW-1:0]      rd_tx, rd_rx;
  logic [NS-1:0]      rd_mask;
  logic [SW-1:0]      off;
  logic [SW-1:0]      base, nxt;
  logic [SB-1:0]      nk;
  logic [NS-1:0]      cur_mask, mask_clr, mask_set;
  logic               more, done;

  assign accept  = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  assign rd_tx   = ps_rdata[PSW-1 -: SW];
  assign rd_rx   = ps_rdata[NS +: SW];
  assign rd_mask = ps_rdata[NS-1:0];

  assign off      = beat_r.seq - rd_rx;
  assign base     = (state_r == S_DRAIN) ? exp_r : rd_rx;
  assign nxt      = base + 1'b1;
  assign nk       = nxt[SB-1:0];
  assign cur_mask = (state_r == S_DRAIN) ? mask_r : rd_mask;
  assign more     = cur_mask[nk];
  assign mask_clr = mask_r & ~(NS'(1) << exp_r[SB-1:0]);
  assign mask_set = rd_mask | (NS'(1) << beat_r.seq[SB-1:0]);
  assign done     = !more || (cnt_r == CW'(psrb_pkg::MAX_RESULTS - 1));

  always_comb begin
    state_nxt   = state_r;
    clr_ptr_nxt = clr_ptr_r;
    beat_nxt    = beat_r;
    p_nxt       = p_r;
    exp_nxt     = exp_r;
    mask_nxt    = mask_r;
    cnt_nxt     = cnt_r;

    res_valid   = 1'b0;
    res.status  = psrb_pkg::ST_PASS;
    res.handle  = beat_r.handle;
    res.seq     = beat_r.seq;
    res.last    = 1'b1;

    ps_we       = 1'b0;
    ps_waddr    = p_r;
    ps_wdata    = {rd_tx, rd_rx, rd_mask};
    ps_re       = accept;
    ps_raddr    = peer_tbl[in_beat.peer];
    hd_we       = 1'b0;
    hd_waddr    = {p_r, beat_r.seq[SB-1:0]};
    hd_wdata    = beat_r.handle[HB-1:0];
    hd_re       = 1'b0;
    hd_raddr    = {p_r, nk};

    case (state_r)
      S_CLEAR: begin
        ps_we    = 1'b1;
        ps_waddr = clr_ptr_r;
        ps_wdata = '0;
        if (clr_ptr_r == PW'(PEERS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_ptr_nxt = clr_ptr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (accept) begin
          beat_nxt        = in_beat;
          beat_nxt.handle = in_beat.handle & HMASK;
          p_nxt           = peer_tbl[in_beat.peer];
          state_nxt       = S_LOOK;
        end
      end

      S_LOOK: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
        if (beat_r.kind == psrb_pkg::KIND_TX) begin
          if (beat_r.local_req) begin
            res.status = psrb_pkg::ST_NUMBERED;
            res.seq    = rd_tx;
            ps_we      = res_ready;
            ps_wdata   = {rd_tx + 1'b1, rd_rx, rd_mask};
          end else begin
            res.status = psrb_pkg::ST_UNNUMBERED;
            res.seq    = '0;
          end
        end else if (!beat_r.numbered || !beat_r.local_req) begin
          res.status = psrb_pkg::ST_PASS;
        end else if (off == '0) begin
          res.status = psrb_pkg::ST_DELIVER;
          res.last   = !more;
          if (res_ready) begin
            if (more) begin
              // fetch the first held handle of the run
              hd_re     = 1'b1;
              exp_nxt   = nxt;
              mask_nxt  = rd_mask;
              cnt_nxt   = CW'(1);
              state_nxt = S_DRAIN;
            end else begin
              ps_we    = 1'b1;
              ps_wdata = {rd_tx, nxt, rd_mask};
            end
          end
        end else if (off < SW'(SPAN)) begin
          res.status = psrb_pkg::ST_HELD;
          ps_we      = res_ready;
          ps_wdata   = {rd_tx, rd_rx, mask_set};
          hd_we      = res_ready;
        end else begin
          res.status = psrb_pkg::ST_DROP;
        end
      end

      S_DRAIN: begin
        res_valid  = 1'b1;
        res.status = psrb_pkg::ST_DELIVER;
        res.handle = psrb_pkg::HANDLE_W'(hd_rdata);
        res.seq    = exp_r;
        res.last   = done;
        if (res_ready) begin
          mask_nxt = mask_clr;
          if (done) begin
            ps_we     = 1'b1;
            ps_wdata  = {rd_tx, nxt, mask_clr};
            state_nxt = S_IDLE;
          end else begin
            hd_re   = 1'b1;
            exp_nxt = nxt;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_ptr_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_ptr_r <= clr_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
    p_r    <= p_nxt;
    exp_r  <= exp_nxt;
    mask_r <= mask_nxt;
    cnt_r  <= cnt_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/per_peer_sequence_reorder_buffer_core.sv =====
// top level of the per-peer sequence reorder buffer: stream ports, output
// register, sequencer and the peer-state and held-handle rams
// depends on psrb_pkg, psrb_ram and psrb_seq
`default_nettype none

//  channel | dir | handshake         | tdata (lsb up)         | tuser (lsb up)
//  --------+-----+-------------------+------------------------+-------------------------
//  in_     | in  | in_tvalid/tready  | peer, seq, handle, pad | kind, numbered, local_req
//  out_    | out | out_tvalid/tready | out_handle, out_seq    | status (+ out_tlast)
//
//  the accept cycle of an item issues the read of the peer's counters and hold
//  mask; in the look state the sequencer decides, emits and writes back
//  a delivery that releases held handles then emits them in order from the drain
//  state, each fetched by the registered read of the held-handle ram
//  after reset a clearing pass zeroes every entry of the peer-state ram,
//  in_tready stays low during it
//  results sit in an output register; while it is full and not taken the
//  sequencer waits, a new beat is taken once the previous item is done

module per_peer_sequence_reorder_buffer_core #(
  parameter int PEERS       = psrb_pkg::DEF_PEERS,
  parameter int WINDOW      = psrb_pkg::DEF_WINDOW,
  parameter int HANDLE_BITS = psrb_pkg::DEF_HANDLE_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,   // peer[3:0], seq[35:4], handle[51:36], zero pad
  input  wire logic [2:0]  in_tuser,   // kind[0], numbered[1], local_req[2]

  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // out_handle[15:0], out_seq[47:16]
  output logic [2:0]       out_tuser,  // status[2:0]
  output logic             out_tlast   // last result of the input beat
);

  localparam int PW   = psrb_pkg::idx_bits(PEERS);
  localparam int SPAN = psrb_pkg::span_of(WINDOW);
  localparam int SB   = $clog2(SPAN);
  localparam int NS   = 1 << SB;
  localparam int HB   = (HANDLE_BITS < psrb_pkg::HANDLE_W) ? HANDLE_BITS
                                                           : psrb_pkg::HANDLE_W;
  localparam int PSW  = 2 * psrb_pkg::SEQ_W + NS;
  localparam int HAW  = PW + SB;

  // unpack the input beat
  psrb_pkg::in_beat_t in_beat;
  assign in_beat.kind      = in_tuser[0];
  assign in_beat.numbered  = in_tuser[1];
  assign in_beat.local_req = in_tuser[2];
  assign in_beat.peer      = in_tdata[3:0];
  assign in_beat.seq       = in_tdata[35:4];
  assign in_beat.handle    = in_tdata[51:36];

  // sequencer to rams
  logic           ps_we, ps_re;
  logic [PW-1:0]  ps_waddr, ps_raddr;
  logic [PSW-1:0] ps_wdata, ps_rdata;
  logic           hd_we, hd_re;
  logic [HAW-1:0] hd_waddr, hd_raddr;
  logic [HB-1:0]  hd_wdata, hd_rdata;

  // sequencer to output register
  logic           res_valid, res_ready;
  psrb_pkg::res_t res;

  // per-peer word: next send number, expected receive number, hold mask
  psrb_ram #(
    .WIDTH (PSW),
    .DEPTH (PEERS)
  ) u_peer_ram (
    .clk   (clk),
    .we    (ps_we),
    .waddr (ps_waddr),
    .wdata (ps_wdata),
    .re    (ps_re),
    .raddr (ps_raddr),
    .rdata (ps_rdata)
  );

  // held handles, one row of slots per peer, slot picked by low seq bits
  psrb_ram #(
    .WIDTH (HB),
    .DEPTH (PEERS * NS)
  ) u_handle_ram (
    .clk   (clk),
    .we    (hd_we),
    .waddr (hd_waddr),
    .wdata (hd_wdata),
    .re    (hd_re),
    .raddr (hd_raddr),
    .rdata (hd_rdata)
  );

  psrb_seq #(
    .PEERS       (PEERS),
    .WINDOW      (WINDOW),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_beat   (in_beat),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ps_we     (ps_we),
    .ps_waddr  (ps_waddr),
    .ps_wdata  (ps_wdata),
    .ps_re     (ps_re),
    .ps_raddr  (ps_raddr),
    .ps_rdata  (ps_rdata),
    .hd_we     (hd_we),
    .hd_waddr  (hd_waddr),
    .hd_wdata  (hd_wdata),
    .hd_re     (hd_re),
    .hd_raddr  (hd_raddr),
    .hd_rdata  (hd_rdata)
  );

  // output register: loads when empty or being drained this cycle
  logic           out_valid_r, out_valid_nxt;
  psrb_pkg::res_t out_res_r;

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.seq, out_res_r.handle};
  assign out_tuser  = out_res_r.status;
  assign out_tlast  = out_res_r.last;

endmodule

`default_nettype wire

// ===== verif/per_peer_sequence_reorder_buffer_core_tb.sv =====
// self-checking testbench for per_peer_sequence_reorder_buffer_core: a directed
// table and then random windowed bursts and loose beats, checked against an in-bench predictor
// depends on psrb_pkg and the rtl of the reorder buffer core

module per_peer_sequence_reorder_buffer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PEERS      = psrb_pkg::DEF_PEERS;
  localparam int WINDOW     = psrb_pkg::DEF_WINDOW;
  // widest hold offset plus one, capped so a drain fits in one run of results
  localparam int SPAN       = (WINDOW < psrb_pkg::MAX_RESULTS) ? WINDOW
                                                               : psrb_pkg::MAX_RESULTS;
  localparam int N_RANDOM   = 150;
  localparam int CALM_TAIL  = 25;    // beats at the end sent with no idling
  localparam int IDLE_LIMIT = 2000;  // cycles with no beat on either side
  localparam int TAIL_WAIT  = 40;    // covers the longest item, a full drain of MAX_RESULTS results

  typedef struct {
    psrb_pkg::in_beat_t beat;
    bit                 typed;  // want below is written out by hand
    psrb_pkg::res_t     want;
  } dir_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata   = '0;  // peer[3:0], seq[35:4], handle[51:36], zero pad
  logic [2:0]  in_tuser   = '0;  // kind[0], numbered[1], local_req[2]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;        // out_handle[15:0], out_seq[47:16]
  logic [2:0]  out_tuser;        // status[2:0]
  logic        out_tlast;

  // predictor state: per-peer counters and the held window
  logic [psrb_pkg::SEQ_W-1:0]    rx_next  [PEERS];
  logic [psrb_pkg::SEQ_W-1:0]    tx_next  [PEERS];
  bit                            held_vld [PEERS*WINDOW];
  logic [psrb_pkg::HANDLE_W-1:0] held_hdl [PEERS*WINDOW];

  psrb_pkg::res_t awaited[$];     // results still to come out, oldest first
  int   err_count  = 0;
  int   beats_sent = 0;
  int   stall_left = 0;
  bit   calm       = 1'b0;

  per_peer_sequence_reorder_buffer_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // works out the results one accepted beat causes and queues them
  task automatic order_messages(input psrb_pkg::in_beat_t b);
    psrb_pkg::res_t             r;
    logic [psrb_pkg::SEQ_W-1:0] off;
    logic [psrb_pkg::SEQ_W-1:0] nxt;
    int                         p;
    int                         idx;
    int                         n;
    p        = b.peer % PEERS;
    r.handle = b.handle;
    r.seq    = b.seq;
    r.last   = 1'b1;
    if (b.kind == psrb_pkg::KIND_TX) begin
      // seq of an outgoing beat is ignored
      if (b.local_req) begin
        r.status   = psrb_pkg::ST_NUMBERED;
        r.seq      = tx_next[p];
        tx_next[p] = tx_next[p] + 1;
      end else begin
        r.status = psrb_pkg::ST_UNNUMBERED;
        r.seq    = '0;
      end
      awaited.push_back(r);
    end else if (!b.numbered || !b.local_req) begin
      r.status = psrb_pkg::ST_PASS;
      awaited.push_back(r);
    end else begin
      off = b.seq - rx_next[p];  // wraps modulo 2^32, stale numbers land high
      if (off == 0) begin
        // in-order delivery, then release the held run that follows
        r.status = psrb_pkg::ST_DELIVER;
        nxt      = b.seq + 1;
        n        = 1;
        idx      = p * WINDOW + int'(nxt % WINDOW);
        while (n < psrb_pkg::MAX_RESULTS && held_vld[idx]) begin
          r.last = 1'b0;
          awaited.push_back(r);
          r.handle      = held_hdl[idx];
          r.seq         = nxt;
          r.last        = 1'b1;
          held_vld[idx] = 1'b0;
          nxt           = nxt + 1;
          n++;
          idx = p * WINDOW + int'(nxt % WINDOW);
        end
        awaited.push_back(r);
        rx_next[p] = nxt;
      end else if (off < SPAN) begin
        // a repeated number just overwrites the stored handle
        idx           = p * WINDOW + int'(b.seq % WINDOW);
        held_vld[idx] = 1'b1;
        held_hdl[idx] = b.handle;
        r.status      = psrb_pkg::ST_HELD;
        awaited.push_back(r);
      end else begin
        r.status = psrb_pkg::ST_DROP;
        awaited.push_back(r);
      end
    end
  endtask

  // drives one beat, with an optional idle burst first, and waits for the accept
  task automatic send_beat(input psrb_pkg::in_beat_t b);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, b.handle, b.seq, b.peer};
    in_tuser  <= {b.local_req, b.numbered, b.kind};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    order_messages(b);
    beats_sent++;
    if (beats_sent >= N_RANDOM + 18 - CALM_TAIL) calm = 1'b1;
  endtask

  // sender holds off until every queued result has come out
  task automatic drain_wait();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited.size() != 0) @(posedge clk);
  endtask

  function automatic dir_row_t mk(input logic kind,
                                  input logic [psrb_pkg::PEER_W-1:0] peer,
                                  input logic [psrb_pkg::SEQ_W-1:0] seq,
                                  input logic [psrb_pkg::HANDLE_W-1:0] hdl,
                                  input logic num, input logic loc, input bit typed,
                                  input logic [psrb_pkg::STATUS_W-1:0] st,
                                  input logic [psrb_pkg::SEQ_W-1:0] want_seq);
    dir_row_t row;
    row.beat.kind      = kind;
    row.beat.peer      = peer;
    row.beat.seq       = seq;
    row.beat.handle    = hdl;
    row.beat.numbered  = num;
    row.beat.local_req = loc;
    row.typed          = typed;
    row.want.status    = st;
    row.want.handle    = hdl;
    row.want.seq       = want_seq;
    row.want.last      = 1'b1;
    return row;
  endfunction

  // a shuffled run of in-window numbers for one peer, so holds and drains happen
  task automatic window_burst();
    psrb_pkg::in_beat_t         b;
    logic [psrb_pkg::SEQ_W-1:0] base;
    int                         order [psrb_pkg::MAX_RESULTS];
    int                         p;
    int                         k;
    int                         j;
    int                         t;
    int                         tmp;
    p    = $urandom_range(0, PEERS - 1);
    k    = ($urandom_range(0, 4) == 0) ? SPAN : $urandom_range(1, 6);
    base = rx_next[p];
    for (j = 0; j < k; j++) order[j] = j;
    for (j = k - 1; j > 0; j--) begin
      t        = $urandom_range(0, j);
      tmp      = order[j];
      order[j] = order[t];
      order[t] = tmp;
    end
    // in-order number last: the whole run is held, then drained at once
    if (k == SPAN || $urandom_range(0, 1) == 1) begin
      for (j = 0; j < k; j++) begin
        if (order[j] == 0) begin
          order[j]     = order[k - 1];
          order[k - 1] = 0;
        end
      end
    end
    for (j = 0; j < k; j++) begin
      b.kind      = psrb_pkg::KIND_RX;
      b.peer      = p[psrb_pkg::PEER_W-1:0];
      b.seq       = base + order[j];
      b.handle    = psrb_pkg::HANDLE_W'($urandom);
      b.numbered  = 1'b1;
      b.local_req = 1'b1;
      send_beat(b);
      if ($urandom_range(0, 9) == 0) begin
        // same number again: duplicate hold or stale drop
        b.handle = psrb_pkg::HANDLE_W'($urandom);
        send_beat(b);
      end
      if ($urandom_range(0, 9) == 0) begin
        b.kind      = psrb_pkg::KIND_TX;
        b.seq       = $urandom;
        b.local_req = 1'($urandom_range(0, 1));
        send_beat(b);
      end
    end
  endtask

  // loose beat: any kind and flags, numbers near, behind or far from the window
  task automatic noise_item();
    psrb_pkg::in_beat_t b;
    int                 p;
    p           = $urandom_range(0, PEERS - 1);
    b.kind      = 1'($urandom_range(0, 1));
    b.peer      = p[psrb_pkg::PEER_W-1:0];
    b.handle    = psrb_pkg::HANDLE_W'($urandom);
    b.numbered  = ($urandom_range(0, 3) != 0);
    b.local_req = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 2))
      0: b.seq = $urandom;
      1: b.seq = rx_next[p] + $urandom_range(0, 20);
      default: b.seq = rx_next[p] - $urandom_range(1, 3);
    endcase
    send_beat(b);
  endtask

  // receiver: ready drops in bursts, and no new burst starts in the calm tail
  always @(posedge clk) begin
    if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 8);
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result checker against the oldest queued result
  always @(posedge clk) begin
    psrb_pkg::res_t got;
    psrb_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.handle = out_tdata[15:0];
      got.seq    = out_tdata[47:16];
      got.last   = out_tlast;
      if (awaited.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result status %0d handle %h seq %h last %0b",
                 $time, got.status, got.handle, got.seq, got.last);
      end else begin
        want = awaited.pop_front();
        if (got.status !== want.status || got.handle !== want.handle ||
            got.seq !== want.seq || got.last !== want.last) begin
          err_count++;
          $display("%0t: mismatch expected status %0d handle %h seq %h last %0b",
                   $time, want.status, want.handle, want.seq, want.last);
          $display("%0t:          actual   status %0d handle %h seq %h last %0b",
                   $time, got.status, got.handle, got.seq, got.last);
        end
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle = 0;
      else
        idle++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    dir_row_t plan[$];
    int       j;
    for (j = 0; j < PEERS; j++) begin
      rx_next[j] = '0;
      tx_next[j] = '0;
    end
    for (j = 0; j < PEERS * WINDOW; j++) held_vld[j] = 1'b0;

    // outgoing: numbering from zero, seq ignored, non-local stays unnumbered
    plan.push_back(mk(psrb_pkg::KIND_TX, 4'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b1, 1'b1,
                      psrb_pkg::ST_NUMBERED, 32'd0));
    plan.push_back(mk(psrb_pkg::KIND_TX, 4'd0, 32'd0, 16'h0000, 1'b1, 1'b1, 1'b1,
                      psrb_pkg::ST_NUMBERED, 32'd1));
    plan.push_back(mk(psrb_pkg::KIND_TX, 4'd15, 32'hFFFF_FFFF, 16'h5A5A, 1'b1, 1'b0, 1'b1,
                      psrb_pkg::ST_UNNUMBERED, 32'd0));
    // passthrough: unnumbered, or not local, or both
    plan.push_back(mk(psrb_pkg::KIND_RX, 4'd15, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b1, 1'b1,
                      psrb_pkg::ST_PASS, 32'hFFFF_FFFF));
    plan.push_back(mk(psrb_pkg::KIND_RX, 4'd7, 32'd0, 16'h0000, 1'b1, 1'b0, 1'b1,
                      psrb_pkg::ST_PASS, 32'd0));
    plan.push_back(mk(psrb_pkg::KIND_RX, 4'd0, 32'h1234_5678, 16'h0F0F, 1'b0, 1'b0, 1'b1,
                      psrb_pkg::ST_PASS, 32'h1234_5678));
    // peer 1: in-order delivery, holds, a duplicate hold and drops
    plan.push_back(mk(psrb_pkg::KIND_RX, 4'd1, 32'd0, 16'hAAAA, 1'b1, 1'b1, 1'b1,
                      psrb_pkg::ST_DELIVER, 32'd0));
    plan.push_back(mk(psrb_pkg::KIND_RX, 4'd1, 32'd3, 16'h0003, 1'b1, 1'b1, 1'b1,
                      psrb_pkg::ST_HELD, 32'd3));
    plan.push_back(mk(psrb_pkg::KIND_RX, 4'd1, 32'd2, 16'h0002, 1'b1, 1'b1, 1'b1,
                      psrb_pkg::ST_HELD, 32'd2));
    plan.push_back(mk(psrb_pkg::KIND_RX, 4'd1, 32'd2, 16'h2222, 1'b1, 1'b1, 1'b1,
                      psrb_pkg::ST_HELD, 32'd2));
    // widest offset still held, one past it dropped
    plan.push_back(mk(psrb_pkg::KIND_RX, 4'd1, 32'd16, 16'h0010, 1'b1, 1'b1, 1'b1,
                      psrb_pkg::ST_HELD, 32'd16));
    plan.push_back(mk(psrb_pkg::KIND_RX, 4'd1, 32'd17, 16'h0011, 1'b1, 1'b1, 1'b1,
                      psrb_pkg::ST_DROP, 32'd17));
    // stale numbers wrap to a huge offset
    plan.push_back(mk(psrb_pkg::KIND_RX, 4'd1, 32'd0, 16'h0BAD, 1'b1, 1'b1, 1'b1,
                      psrb_pkg::ST_DROP, 32'd0));
    plan.push_back(mk(psrb_pkg::KIND_RX, 4'd1, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1,
                      psrb_pkg::ST_DROP, 32'hFFFF_FFFF));
    // missing number arrives: drains the overwritten 2 and then 3
    plan.push_back(mk(psrb_pkg::KIND_RX, 4'd1, 32'd1, 16'h0001, 1'b1, 1'b1, 1'b0,
                      psrb_pkg::ST_PASS, 32'd0));
    plan.push_back(mk(psrb_pkg::KIND_RX, 4'd1, 32'd4, 16'h0004, 1'b1, 1'b1, 1'b0,
                      psrb_pkg::ST_PASS, 32'd0));
    // top peer index
    plan.push_back(mk(psrb_pkg::KIND_TX, 4'd15, 32'd0, 16'h1234, 1'b0, 1'b1, 1'b1,
                      psrb_pkg::ST_NUMBERED, 32'd0));
    plan.push_back(mk(psrb_pkg::KIND_RX, 4'd15, 32'd0, 16'hFFFF, 1'b1, 1'b1, 1'b1,
                      psrb_pkg::ST_DELIVER, 32'd0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      send_beat(plan[i].beat);
      if (plan[i].typed) begin
        // hand-written expectation replaces the predicted one
        void'(awaited.pop_back());
        awaited.push_back(plan[i].want);
      end
    end
    drain_wait();

    // random part: mostly well-formed bursts, the rest loose beats
    while (beats_sent < plan.size() + N_RANDOM) begin
      if ($urandom_range(0, 9) < 6)
        window_burst();
      else
        noise_item();
      if ($urandom_range(0, 11) == 0) drain_wait();
    end

    drain_wait();
    repeat (TAIL_WAIT) @(posedge clk);
    if (err_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/psrb_pkg.sv
rtl/core/psrb_ram.sv
rtl/core/psrb_seq.sv
rtl/core/per_peer_sequence_reorder_buffer_core.sv
verif/per_peer_sequence_reorder_buffer_core_tb.sv
